@@ rtl/aksu_pkg.sv @@
`timescale 1ns / 1ps
package aksu_pkg;

  localparam int unsigned KeyBytes = 16;
  localparam int unsigned NumRounds = 10;

  typedef struct packed {
    logic       first_byte;
    logic [31:0] string_offset;
    logic [31:0] string_size;
    logic [7:0]  cipher_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] plain_byte;
    logic       last_byte;
  } out_word_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] gf_double(input logic [7:0] x);
    gf_double = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

endpackage

@@ rtl/aksu_stream_if.sv @@
`timescale 1ns / 1ps
interface aksu_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/aksu_aes_core.sv @@
`timescale 1ns / 1ps
module aksu_aes_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [127:0] key_i,
  output logic         done_o,
  output logic [127:0] mask_o
);
  import aksu_pkg::*;

  // One round per cycle; the round key is expanded alongside the state.
  logic [127:0] state_q, state_d;
  logic [127:0] rkey_q, rkey_d;
  logic [7:0]   rcon_q, rcon_d;
  logic [3:0]   round_q, round_d;
  logic         busy_q, busy_d;
  logic         done_q, done_d;

  logic [7:0]   st_b [16];
  logic [7:0]   rk_b [16];
  logic [7:0]   sr_b [16];
  logic [7:0]   mc_b [16];
  logic [7:0]   nk_b [16];
  logic [127:0] next_state, next_key;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      st_b[i] = state_q[8*i +: 8];
      rk_b[i] = rkey_q[8*i +: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr_b[c*4+r] = SBOX[st_b[((c + r) % 4)*4 + r]];
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3, al;
      a0 = sr_b[c*4]; a1 = sr_b[c*4+1]; a2 = sr_b[c*4+2]; a3 = sr_b[c*4+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      mc_b[c*4]   = a0 ^ al ^ gf_double(a0 ^ a1);
      mc_b[c*4+1] = a1 ^ al ^ gf_double(a1 ^ a2);
      mc_b[c*4+2] = a2 ^ al ^ gf_double(a2 ^ a3);
      mc_b[c*4+3] = a3 ^ al ^ gf_double(a3 ^ a0);
    end
    nk_b[0] = rk_b[0] ^ SBOX[rk_b[13]] ^ rcon_q;
    nk_b[1] = rk_b[1] ^ SBOX[rk_b[14]];
    nk_b[2] = rk_b[2] ^ SBOX[rk_b[15]];
    nk_b[3] = rk_b[3] ^ SBOX[rk_b[12]];
    for (int i = 4; i < 16; i++) begin
      nk_b[i] = rk_b[i] ^ nk_b[i-4];
    end
    for (int i = 0; i < 16; i++) begin
      next_key[8*i +: 8] = nk_b[i];
      next_state[8*i +: 8] = ((round_q == 4'(NumRounds)) ? sr_b[i] : mc_b[i]) ^ nk_b[i];
    end
  end

  always_comb begin
    state_d = state_q;
    rkey_d  = rkey_q;
    rcon_d  = rcon_q;
    round_d = round_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      state_d = key_i;
      rkey_d  = key_i;
      rcon_d  = 8'h01;
      round_d = 4'd1;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      state_d = next_state;
      rkey_d  = next_key;
      rcon_d  = gf_double(rcon_q);
      round_d = round_q + 4'd1;
      if (round_q == 4'(NumRounds)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      round_q <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      round_q <= round_d;
    end
  end

  always_ff @(posedge clk_i) begin
    state_q <= state_d;
    rkey_q  <= rkey_d;
    rcon_q  <= rcon_d;
  end

  assign done_o = done_q;
  assign mask_o = state_q;
endmodule

@@ rtl/aes_keyed_string_unmask.sv @@
`timescale 1ns / 1ps
// A first word loads the AES core, which runs 10 AES rounds in one shared round
// unit before its result is registered; any other word is registered directly.
// Throughput: one word per cycle between first words, unless out_o.ready stalls.
// Reset: asynchronous, active low; mask, byte index and held size clear to zero.
module aes_keyed_string_unmask (
  input  logic clk_i,
  input  logic rst_ni,
  aksu_stream_if.sink   in_i,
  aksu_stream_if.source out_o
);
  import aksu_pkg::*;

  localparam logic [1:0] StRun  = 2'd0;
  localparam logic [1:0] StAes  = 2'd1;
  localparam logic [1:0] StHold = 2'd2;

  logic [1:0]   st_q, st_d;
  logic [7:0]   mask_q [KeyBytes];
  logic [31:0]  idx_q, size_q;
  logic [7:0]   byte_q;
  logic         ov_q;
  out_word_t    res_q;
  logic         aes_start, aes_done;
  logic [127:0] aes_mask;
  in_word_t     iw;
  logic         take, out_free;
  logic         proc;
  logic [31:0]  p_idx, p_size;
  logic [7:0]   p_byte, p_mask;
  logic [3:0]   slot;

  assign iw       = in_i.data;
  assign out_free = !ov_q || out_o.ready;
  assign in_i.ready = (st_q == StRun) && out_free;
  assign take     = in_i.valid && in_i.ready;
  assign aes_start = take && iw.first_byte;

  aksu_aes_core u_aes (
    .clk_i, .rst_ni,
    .start_i(aes_start),
    .key_i  ({64'd0, iw.string_size, iw.string_offset}),
    .done_o (aes_done),
    .mask_o (aes_mask)
  );

  // A plain word is processed on acceptance; a first word after the AES run.
  assign proc   = (take && !iw.first_byte) || aes_done;
  assign p_idx  = aes_done ? 32'd0 : idx_q;
  assign p_size = size_q;
  assign p_byte = aes_done ? byte_q : iw.cipher_byte;
  assign slot   = p_idx[3:0];
  assign p_mask = aes_done ? aes_mask[8*slot +: 8] : mask_q[slot];

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StRun:   if (aes_start) st_d = StAes;
      StAes:   if (aes_done) st_d = StRun;
      default: st_d = StRun;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StRun;
      idx_q  <= '0;
      size_q <= '0;
      ov_q   <= 1'b0;
      for (int i = 0; i < KeyBytes; i++) mask_q[i] <= '0;
    end else begin
      st_q <= st_d;
      if (aes_start) begin
        size_q <= iw.string_size;
      end
      if (aes_done) begin
        for (int i = 0; i < KeyBytes; i++) mask_q[i] <= aes_mask[8*i +: 8];
      end
      if (proc) begin
        mask_q[slot] <= p_mask + p_idx[7:0];
        idx_q        <= p_idx + 32'd1;
        ov_q         <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (aes_start) byte_q <= iw.cipher_byte;
    if (proc) begin
      res_q.plain_byte <= p_byte ^ p_mask;
      res_q.last_byte  <= (p_idx + 32'd1) == p_size;
    end
  end

  assign out_o.valid = ov_q;
  assign out_o.data  = res_q;

  // StHold is reserved; the run state machine never enters it.
  a_no_hold: assert property (@(posedge clk_i) disable iff (!rst_ni) st_q != StHold)
    else $error("unexpected state");
  a_done_in_aes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    aes_done |-> st_q == StAes) else $error("AES done outside run");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_o.ready) |=> $stable(res_q)) else $error("result overwritten");
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    aes_start |=> !in_i.ready) else $error("ready during AES");
endmodule
